// File: sv/skti_pkg.sv
// Shared types, codes and sizes for the sorted keyframe table.
package skti_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [CNT_W-1:0] cnt_type;
   typedef logic signed [15:0] frame_type;
   typedef logic [1:0] flags_type;
   typedef logic [5:0] slot_type;
   typedef logic [5:0] ridx_type;
   typedef logic [6:0] count_out_type;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_READ   = 2'd1,
      OP_CLEAR  = 2'd2,
      OP_NOP    = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_RANGE = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_SCAN,
      ST_SHIFT,
      ST_READ
   } state_type;

   // Datapath action for the current cycle.
   typedef enum logic [3:0] {
      ACT_NONE,
      ACT_LOAD,
      ACT_START_SCAN,
      ACT_READ,
      ACT_SCAN_STEP,
      ACT_MERGE,
      ACT_PLACE,
      ACT_APPEND,
      ACT_SHIFT,
      ACT_SHIFT_END,
      ACT_FULL,
      ACT_READ_RESULT,
      ACT_RANGE,
      ACT_CLEAR,
      ACT_NOP_RESULT
   } act_type;

   typedef struct packed {
      act_type act;
      logic    finish;
   } cmd_type;

   typedef struct packed {
      opcode_type op;
      logic       out_free;
      logic       empty;
      logic       full;
      logic       eq;
      logic       lt;
      logic       last;
      logic       at_end;
      logic       read_ok;
   } stat_type;

endpackage

// File: sv/sorted_keyframe_table_insert.sv
// Top level of the sorted keyframe table: controller, datapath and checks.
//
// Keeps up to TABLE_DEPTH (64) keyframe entries in ascending signed frame
// order, each with two key flags (position, rotation). Opcode 0 inserts a
// key: an equal frame ORs its flags into the stored entry (merged = 1),
// otherwise the new entry goes before the first larger frame and later
// entries move up one slot, or it lands at the end; a new frame into a full
// table returns status 1 and leaves the table alone. Opcode 1 reads one slot
// (status 2 if the slot is at or beyond the count), opcode 2 empties the
// table, and opcode 3 only reports the count. Every request word yields
// exactly one response word, and entry_count always shows the count after
// the operation. Timing is set by the entry memory, which has one read and
// one write per cycle: the scan walks it one slot per cycle and the shift
// then rewrites it one slot per cycle. An insert scans from slot 0 to the
// first equal or larger frame and merges into an equal one; before a larger
// one it shifts the later entries up, and past the last entry it appends.
// An insert into an empty table appends without a scan. A read makes one
// memory read before it answers, and a clear or no-op answers from the
// start state without touching the memory. One request is worked on at a
// time; the next request word is accepted while the previous response word
// is still waiting, and work on it starts once that response is taken. The
// entry memory needs no clearing after reset; data read from slots at or
// above the count is never used.
module sorted_keyframe_table_insert (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  logic [1:0]   req_opcode,
   input  logic signed [15:0] req_frame,
   input  logic [1:0]   req_key_flags,
   input  logic [5:0]   req_read_index,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output logic [1:0]   rsp_status,
   output logic [5:0]   rsp_slot,
   output logic         rsp_merged,
   output logic signed [15:0] rsp_entry_frame,
   output logic [1:0]   rsp_entry_flags,
   output logic [6:0]   rsp_entry_count
);

   skti_pkg::cmd_type  cmd;
   skti_pkg::stat_type stat;

   // Sequence the scan, shift and result steps.
   skti_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Hold the entries, compare against the request frame, build the response.
   skti_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_opcode      (req_opcode),
      .req_frame       (req_frame),
      .req_key_flags   (req_key_flags),
      .req_read_index  (req_read_index),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_slot        (rsp_slot),
      .rsp_merged      (rsp_merged),
      .rsp_entry_frame (rsp_entry_frame),
      .rsp_entry_flags (rsp_entry_flags),
      .rsp_entry_count (rsp_entry_count)
   );

   // Drop ready after taking a word: one request in flight at a time.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while another is in flight");

   // A table-full response never merges and only comes with a full table.
   a_full_consistent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == skti_pkg::STATUS_FULL |->
         !rsp_merged && int'(rsp_entry_count) == (skti_pkg::TABLE_DEPTH % 128))
      else $error("full status with merge or with room left");

   // A merge always reports success.
   a_merge_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_merged |-> rsp_status == skti_pkg::STATUS_OK)
      else $error("merged response with error status");

   // The count never changes while a response word is waiting.
   a_count_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_entry_count))
      else $error("entry count moved under a pending response");

endmodule

// File: sv/skti_ctrl.sv
// Controller state machine for the sorted keyframe table.
module skti_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  skti_pkg::stat_type stat,
   output skti_pkg::cmd_type  cmd
);

   skti_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= skti_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         skti_pkg::ST_IDLE: begin
            if (req_valid) state_in = skti_pkg::ST_START;
         end
         skti_pkg::ST_START: begin
            if (stat.out_free) begin
               case (stat.op)
                  skti_pkg::OP_INSERT: begin
                     state_in = stat.empty ? skti_pkg::ST_IDLE : skti_pkg::ST_SCAN;
                  end
                  skti_pkg::OP_READ: begin
                     state_in = stat.read_ok ? skti_pkg::ST_READ : skti_pkg::ST_IDLE;
                  end
                  default: state_in = skti_pkg::ST_IDLE;
               endcase
            end
         end
         skti_pkg::ST_SCAN: begin
            if (stat.eq) begin
               state_in = skti_pkg::ST_IDLE;
            end else if (stat.lt) begin
               state_in = stat.full ? skti_pkg::ST_IDLE : skti_pkg::ST_SHIFT;
            end else if (stat.last) begin
               state_in = skti_pkg::ST_IDLE;
            end
         end
         skti_pkg::ST_SHIFT: begin
            if (stat.at_end) state_in = skti_pkg::ST_IDLE;
         end
         skti_pkg::ST_READ: state_in = skti_pkg::ST_IDLE;
         default: state_in = skti_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready  = 1'b0;
      cmd.act    = skti_pkg::ACT_NONE;
      cmd.finish = 1'b0;
      case (state_ff)
         skti_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) cmd.act = skti_pkg::ACT_LOAD;
         end
         skti_pkg::ST_START: begin
            if (stat.out_free) begin
               case (stat.op)
                  skti_pkg::OP_INSERT: begin
                     if (stat.empty) begin
                        cmd.act    = skti_pkg::ACT_APPEND;
                        cmd.finish = 1'b1;
                     end else begin
                        cmd.act = skti_pkg::ACT_START_SCAN;
                     end
                  end
                  skti_pkg::OP_READ: begin
                     if (stat.read_ok) begin
                        cmd.act = skti_pkg::ACT_READ;
                     end else begin
                        cmd.act    = skti_pkg::ACT_RANGE;
                        cmd.finish = 1'b1;
                     end
                  end
                  skti_pkg::OP_CLEAR: begin
                     cmd.act    = skti_pkg::ACT_CLEAR;
                     cmd.finish = 1'b1;
                  end
                  default: begin
                     cmd.act    = skti_pkg::ACT_NOP_RESULT;
                     cmd.finish = 1'b1;
                  end
               endcase
            end
         end
         skti_pkg::ST_SCAN: begin
            if (stat.eq) begin
               cmd.act    = skti_pkg::ACT_MERGE;
               cmd.finish = 1'b1;
            end else if (stat.lt) begin
               if (stat.full) begin
                  cmd.act    = skti_pkg::ACT_FULL;
                  cmd.finish = 1'b1;
               end else begin
                  cmd.act = skti_pkg::ACT_PLACE;
               end
            end else if (stat.last) begin
               cmd.act    = stat.full ? skti_pkg::ACT_FULL : skti_pkg::ACT_APPEND;
               cmd.finish = 1'b1;
            end else begin
               cmd.act = skti_pkg::ACT_SCAN_STEP;
            end
         end
         skti_pkg::ST_SHIFT: begin
            if (stat.at_end) begin
               cmd.act    = skti_pkg::ACT_SHIFT_END;
               cmd.finish = 1'b1;
            end else begin
               cmd.act = skti_pkg::ACT_SHIFT;
            end
         end
         skti_pkg::ST_READ: begin
            cmd.act    = skti_pkg::ACT_READ_RESULT;
            cmd.finish = 1'b1;
         end
         default: ;
      endcase
   end

endmodule

// File: sv/skti_dpath.sv
// Datapath for the sorted keyframe table: entry memory, scan index, carry and result words.
module skti_dpath (
   input  logic                     clock,
   input  logic                     reset,
   input  skti_pkg::cmd_type        cmd,
   output skti_pkg::stat_type       stat,
   input  logic [1:0]               req_opcode,
   input  skti_pkg::frame_type      req_frame,
   input  skti_pkg::flags_type      req_key_flags,
   input  skti_pkg::ridx_type       req_read_index,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [1:0]               rsp_status,
   output skti_pkg::slot_type       rsp_slot,
   output logic                     rsp_merged,
   output skti_pkg::frame_type      rsp_entry_frame,
   output skti_pkg::flags_type      rsp_entry_flags,
   output skti_pkg::count_out_type  rsp_entry_count
);

   // Entry memory, no reset: data read from slots at or above the count is never used.
   skti_pkg::frame_type frame_mem_ff [skti_pkg::TABLE_DEPTH];
   skti_pkg::flags_type flag_mem_ff  [skti_pkg::TABLE_DEPTH];

   skti_pkg::opcode_type op_ff;
   skti_pkg::frame_type  frame_ff, carry_frame_ff, rd_frame_ff, res_frame_ff;
   skti_pkg::flags_type  flags_ff, carry_flags_ff, rd_flags_ff, res_flags_ff;
   skti_pkg::ridx_type   ridx_ff;
   skti_pkg::cnt_type    idx_ff, count_ff, next_idx;
   skti_pkg::status_type res_status_ff;
   skti_pkg::slot_type   res_slot_ff;
   logic                 res_merged_ff;
   logic                 rsp_valid_ff;

   logic                 wr_en, rd_en;
   skti_pkg::idx_type    wr_addr, rd_addr;
   skti_pkg::frame_type  wr_frame;
   skti_pkg::flags_type  wr_flags;
   skti_pkg::flags_type  merge_flags;

   assign next_idx    = idx_ff + skti_pkg::cnt_type'(1);
   assign merge_flags = rd_flags_ff | flags_ff;

   assign stat.op       = op_ff;
   assign stat.out_free = !rsp_valid_ff || rsp_ready;
   assign stat.empty    = (count_ff == '0);
   assign stat.full     = (count_ff == skti_pkg::cnt_type'(skti_pkg::TABLE_DEPTH));
   assign stat.eq       = (frame_ff == rd_frame_ff);
   assign stat.lt       = (frame_ff < rd_frame_ff);
   assign stat.last     = (next_idx == count_ff);
   assign stat.at_end   = (idx_ff == count_ff);
   assign stat.read_ok  = (int'(ridx_ff) < int'(count_ff));

   always_comb begin
      wr_en    = 1'b0;
      wr_addr  = skti_pkg::idx_type'(idx_ff);
      wr_frame = frame_ff;
      wr_flags = flags_ff;
      rd_en    = 1'b0;
      rd_addr  = skti_pkg::idx_type'(next_idx);
      case (cmd.act)
         skti_pkg::ACT_START_SCAN: begin
            rd_en   = 1'b1;
            rd_addr = '0;
         end
         skti_pkg::ACT_READ: begin
            rd_en   = 1'b1;
            rd_addr = skti_pkg::idx_type'(ridx_ff);
         end
         skti_pkg::ACT_SCAN_STEP: rd_en = 1'b1;
         skti_pkg::ACT_MERGE: begin
            wr_en    = 1'b1;
            wr_frame = rd_frame_ff;
            wr_flags = merge_flags;
         end
         skti_pkg::ACT_PLACE: begin
            wr_en = 1'b1;
            rd_en = 1'b1;
         end
         skti_pkg::ACT_APPEND: begin
            wr_en   = 1'b1;
            wr_addr = skti_pkg::idx_type'(count_ff);
         end
         skti_pkg::ACT_SHIFT: begin
            wr_en    = 1'b1;
            rd_en    = 1'b1;
            wr_frame = carry_frame_ff;
            wr_flags = carry_flags_ff;
         end
         skti_pkg::ACT_SHIFT_END: begin
            wr_en    = 1'b1;
            wr_frame = carry_frame_ff;
            wr_flags = carry_flags_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         frame_mem_ff[wr_addr] <= wr_frame;
         flag_mem_ff[wr_addr]  <= wr_flags;
      end
      if (rd_en) begin
         rd_frame_ff <= frame_mem_ff[rd_addr];
         rd_flags_ff <= flag_mem_ff[rd_addr];
      end
   end

   // Control state: entry count and result valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.act == skti_pkg::ACT_APPEND || cmd.act == skti_pkg::ACT_SHIFT_END) begin
            count_ff <= count_ff + skti_pkg::cnt_type'(1);
         end else if (cmd.act == skti_pkg::ACT_CLEAR) begin
            count_ff <= '0;
         end
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload: request word, scan index, carry and result.
   always_ff @(posedge clock) begin
      case (cmd.act)
         skti_pkg::ACT_LOAD: begin
            op_ff    <= skti_pkg::opcode_type'(req_opcode);
            frame_ff <= req_frame;
            flags_ff <= req_key_flags;
            ridx_ff  <= req_read_index;
         end
         skti_pkg::ACT_START_SCAN: idx_ff <= '0;
         skti_pkg::ACT_SCAN_STEP:  idx_ff <= next_idx;
         skti_pkg::ACT_MERGE: begin
            res_status_ff <= skti_pkg::STATUS_OK;
            res_slot_ff   <= skti_pkg::slot_type'(idx_ff);
            res_merged_ff <= 1'b1;
            res_frame_ff  <= rd_frame_ff;
            res_flags_ff  <= merge_flags;
         end
         skti_pkg::ACT_PLACE: begin
            carry_frame_ff <= rd_frame_ff;
            carry_flags_ff <= rd_flags_ff;
            idx_ff         <= next_idx;
            res_status_ff  <= skti_pkg::STATUS_OK;
            res_slot_ff    <= skti_pkg::slot_type'(idx_ff);
            res_merged_ff  <= 1'b0;
            res_frame_ff   <= frame_ff;
            res_flags_ff   <= flags_ff;
         end
         skti_pkg::ACT_APPEND: begin
            res_status_ff <= skti_pkg::STATUS_OK;
            res_slot_ff   <= skti_pkg::slot_type'(count_ff);
            res_merged_ff <= 1'b0;
            res_frame_ff  <= frame_ff;
            res_flags_ff  <= flags_ff;
         end
         skti_pkg::ACT_SHIFT: begin
            carry_frame_ff <= rd_frame_ff;
            carry_flags_ff <= rd_flags_ff;
            idx_ff         <= next_idx;
         end
         skti_pkg::ACT_FULL: begin
            res_status_ff <= skti_pkg::STATUS_FULL;
            res_slot_ff   <= '0;
            res_merged_ff <= 1'b0;
            res_frame_ff  <= '0;
            res_flags_ff  <= '0;
         end
         skti_pkg::ACT_READ_RESULT: begin
            res_status_ff <= skti_pkg::STATUS_OK;
            res_slot_ff   <= ridx_ff;
            res_merged_ff <= 1'b0;
            res_frame_ff  <= rd_frame_ff;
            res_flags_ff  <= rd_flags_ff;
         end
         skti_pkg::ACT_RANGE: begin
            res_status_ff <= skti_pkg::STATUS_RANGE;
            res_slot_ff   <= ridx_ff;
            res_merged_ff <= 1'b0;
            res_frame_ff  <= '0;
            res_flags_ff  <= '0;
         end
         skti_pkg::ACT_CLEAR, skti_pkg::ACT_NOP_RESULT: begin
            res_status_ff <= skti_pkg::STATUS_OK;
            res_slot_ff   <= '0;
            res_merged_ff <= 1'b0;
            res_frame_ff  <= '0;
            res_flags_ff  <= '0;
         end
         default: ;
      endcase
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = res_status_ff;
   assign rsp_slot        = res_slot_ff;
   assign rsp_merged      = res_merged_ff;
   assign rsp_entry_frame = res_frame_ff;
   assign rsp_entry_flags = res_flags_ff;
   assign rsp_entry_count = skti_pkg::count_out_type'(count_ff);

endmodule
